// ===== rtl/core/milenage_auth_vector_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef MILENAGE_AUTH_VECTOR_DEFINES_SVH
`define MILENAGE_AUTH_VECTOR_DEFINES_SVH

// same-cycle implication, ignored during reset
`define MAV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, ignored during reset
`define MAV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset as well
`define MAV_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mav_pkg.sv =====
package mav_pkg;

  typedef logic [127:0] blk_t;

  // queued job: RAND^OPc, the prepared f1 operand and SQN
  typedef struct packed {
    blk_t        x;
    blk_t        w1;
    logic [47:0] sqn;
  } job_t;

  // result vector, first field in the highest bits
  typedef struct packed {
    logic [63:0] autn_low;
    logic [63:0] autn_high;
    logic [47:0] anonymity_key;
    logic [63:0] integrity_key_low;
    logic [63:0] integrity_key_high;
    logic [63:0] cipher_key_low;
    logic [63:0] cipher_key_high;
    logic [63:0] expected_response;
  } vec_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_OPC_HIGH = 3'd2,
    REG_OPC_LOW  = 3'd3,
    REG_AMF      = 3'd4
  } cfg_reg_t;

  localparam int NUM_ROUNDS = 10;

  // Milenage constants c2..c4 (c1 is zero), applied on the last byte
  localparam logic [7:0] C2 = 8'h01;
  localparam logic [7:0] C3 = 8'h02;
  localparam logic [7:0] C4 = 8'h04;
  // rotations in bytes: r1 = 64, r3 = 32, r4 = 64 bits
  localparam int R1_BYTES = 8;
  localparam int R3_BYTES = 4;
  localparam int R4_BYTES = 8;

  localparam logic [7:0] RCON_TAB [NUM_ROUNDS] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // rotate left by whole bytes; byte 0 is the top byte
  function automatic blk_t rotl_bytes(blk_t a, int nb);
    blk_t r;
    r = a;
    if (nb != 0) begin
      r = (a << (8 * nb)) | (a >> (128 - 8 * nb));
    end
    return r;
  endfunction

  // one step of the AES-128 key schedule
  function automatic blk_t key_step(blk_t rk, logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, MixColumns (skipped on the last round), AddRoundKey
  function automatic blk_t aes_round(blk_t s, blk_t rk, logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    blk_t o;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4 * c] = SBOX[s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c];
        a1 = t[4 * c + 1];
        a2 = t[4 * c + 2];
        a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      o[127 - 8 * i -: 8] = t[i] ^ rk[127 - 8 * i -: 8];
    end
    return o;
  endfunction

endpackage

// ===== rtl/core/mav_front.sv =====
// Input side: forms RAND^OPc and the f1 operand rot(IN1^OPc, r1).
module mav_front import mav_pkg::*; (
  input  logic [63:0]  rand_high,
  input  logic [63:0]  rand_low,
  input  logic [47:0]  sequence_number,
  input  blk_t         opc,
  input  logic [15:0]  amf,
  output job_t         job
);

  blk_t in1;

  assign in1     = {sequence_number, amf, sequence_number, amf};
  assign job.x   = {rand_high, rand_low} ^ opc;
  assign job.w1  = rotl_bytes(in1 ^ opc, R1_BYTES);
  assign job.sqn = sequence_number;

endmodule

// ===== rtl/core/mav_queue.sv =====
// Two-entry job queue between front and back.
module mav_queue import mav_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head
);

  job_t       slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign full     = count[1];
  assign nonempty = (count != 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;
  assign head     = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= push_job;
  end

endmodule

// ===== rtl/core/mav_round.sv =====
// One registered AES round over LANES blocks sharing a round key.
module mav_round import mav_pkg::*; #(
  parameter int         LANES = 1,
  parameter logic [7:0] RCON  = 8'h01,
  parameter bit         LAST  = 1'b0
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [LANES-1:0][127:0] st_in,
  input  blk_t                  rk_in,
  output logic [LANES-1:0][127:0] st_out,
  output blk_t                  rk_out
);

  blk_t rk_next;

  assign rk_next = key_step(rk_in, RCON);

  always_ff @(posedge clk) begin
    if (en) begin
      rk_out <= rk_next;
      for (int l = 0; l < LANES; l++) begin
        st_out[l] <= aes_round(st_in[l], rk_next, LAST);
      end
    end
  end

endmodule

// ===== rtl/core/mav_back.sv =====
// Execution side: ten rounds for TEMP, then ten rounds for f1..f4 in four
// lanes, then the result register.
module mav_back import mav_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  output logic        job_pop,
  input  blk_t        key,
  input  blk_t        opc,
  input  logic [15:0] amf,
  output logic        res_valid,
  input  logic        res_ready,
  output vec_t        res
);

  localparam int NL = 4;

  logic adv;
  logic [NUM_ROUNDS:1] a_v, b_v;

  blk_t        a_st [NUM_ROUNDS+1];
  blk_t        a_rk [NUM_ROUNDS+1];
  blk_t        a_w1 [NUM_ROUNDS+1];
  logic [47:0] a_sq [NUM_ROUNDS+1];

  logic [NL-1:0][127:0] b_st [NUM_ROUNDS+1];
  blk_t                 b_rk [NUM_ROUNDS+1];
  logic [47:0]          b_sq [NUM_ROUNDS+1];

  blk_t temp, tx, o1, o2, o3, o4;
  vec_t vec;

  // whole back end moves together; stalls only when the result is held
  assign adv     = !res_valid || res_ready;
  assign job_pop = adv && job_valid;

  assign a_st[0] = job.x ^ key;
  assign a_rk[0] = key;
  assign a_w1[0] = job.w1;
  assign a_sq[0] = job.sqn;

  // lanes: 0 = f1, 1 = f2/f5, 2 = f3, 3 = f4
  assign temp = a_st[NUM_ROUNDS];
  assign tx   = temp ^ opc;
  assign b_st[0][0] = temp ^ a_w1[NUM_ROUNDS] ^ key;
  assign b_st[0][1] = tx ^ {120'd0, C2} ^ key;
  assign b_st[0][2] = rotl_bytes(tx, R3_BYTES) ^ {120'd0, C3} ^ key;
  assign b_st[0][3] = rotl_bytes(tx, R4_BYTES) ^ {120'd0, C4} ^ key;
  assign b_rk[0] = key;
  assign b_sq[0] = a_sq[NUM_ROUNDS];

  for (genvar j = 0; j < NUM_ROUNDS; j++) begin : g_rnd
    mav_round #(
      .LANES(1),
      .RCON (RCON_TAB[j]),
      .LAST (j == NUM_ROUNDS - 1)
    ) u_a (
      .clk   (clk),
      .en    (adv),
      .st_in (a_st[j]),
      .rk_in (a_rk[j]),
      .st_out(a_st[j+1]),
      .rk_out(a_rk[j+1])
    );

    mav_round #(
      .LANES(NL),
      .RCON (RCON_TAB[j]),
      .LAST (j == NUM_ROUNDS - 1)
    ) u_b (
      .clk   (clk),
      .en    (adv),
      .st_in (b_st[j]),
      .rk_in (b_rk[j]),
      .st_out(b_st[j+1]),
      .rk_out(b_rk[j+1])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        a_w1[j+1] <= a_w1[j];
        a_sq[j+1] <= a_sq[j];
        b_sq[j+1] <= b_sq[j];
      end
    end
  end

  assign o1 = b_st[NUM_ROUNDS][0] ^ opc;
  assign o2 = b_st[NUM_ROUNDS][1] ^ opc;
  assign o3 = b_st[NUM_ROUNDS][2] ^ opc;
  assign o4 = b_st[NUM_ROUNDS][3] ^ opc;

  always_comb begin
    vec.expected_response  = o2[63:0];
    vec.cipher_key_high    = o3[127:64];
    vec.cipher_key_low     = o3[63:0];
    vec.integrity_key_high = o4[127:64];
    vec.integrity_key_low  = o4[63:0];
    vec.anonymity_key      = o2[127:80];
    vec.autn_high          = {b_sq[NUM_ROUNDS] ^ o2[127:80], amf};
    vec.autn_low           = o1[127:64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= '0;
      b_v       <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= {a_v[NUM_ROUNDS-1:1], job_valid};
      b_v       <= {b_v[NUM_ROUNDS-1:1], a_v[NUM_ROUNDS]};
      res_valid <= b_v[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res <= vec;
  end

endmodule

// ===== rtl/core/milenage_auth_vector.sv =====
// Channel  Dir  Width  Contents (lowest bit first)
// s_axis   in   176    rand_high, rand_low, sequence_number
// m_axis   out  496    expected_response, cipher_key_high/low, integrity_key_high/low,
//                      anonymity_key, autn_high, autn_low
// cfg      in   64     key_high, key_low, opc_high, opc_low, auth_mgmt_field
//
// One vector per clock sustained while m_axis accepts; from input transfer to
// m_axis_tvalid a job passes ten TEMP rounds, ten f1..f4 rounds and the result
// register (the queue slot is written on the input transfer edge itself).
// Each AES round is one pipeline stage with its own round-key step.
// rst is synchronous and clears the queue, stage valids and config registers.
// A stalled m_axis freezes the back end; the two-entry queue keeps s_axis
// taking transfers until it fills.
module milenage_auth_vector import mav_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,   // rand_high, rand_low, sequence_number
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [495:0] m_axis_tdata,   // expected_response, cipher_key_high,
                                       // cipher_key_low, integrity_key_high,
                                       // integrity_key_low, anonymity_key,
                                       // autn_high, autn_low
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [63:0] key_high, key_low, opc_high, opc_low;
  logic [15:0] amf;
  blk_t        key, opc;

  job_t job_in, job_head;
  logic q_full, q_nonempty, q_pop;
  vec_t res;

  assign key = {key_high, key_low};
  assign opc = {opc_high, opc_low};

  // config registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
      opc_high <= '0;
      opc_low  <= '0;
      amf      <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_high <= cfg_data;
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_OPC_HIGH: opc_high <= cfg_data;
        REG_OPC_LOW:  opc_low  <= cfg_data;
        REG_AMF:      amf      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mav_front u_front (
    .rand_high      (s_axis_tdata[63:0]),
    .rand_low       (s_axis_tdata[127:64]),
    .sequence_number(s_axis_tdata[175:128]),
    .opc            (opc),
    .amf            (amf),
    .job            (job_in)
  );

  // ready only reflects queue space, not back-end activity
  assign s_axis_tready = !q_full;

  mav_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (s_axis_tvalid),
    .push_job(job_in),
    .full    (q_full),
    .pop     (q_pop),
    .nonempty(q_nonempty),
    .head    (job_head)
  );

  mav_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(q_nonempty),
    .job      (job_head),
    .job_pop  (q_pop),
    .key      (key),
    .opc      (opc),
    .amf      (amf),
    .res_valid(m_axis_tvalid),
    .res_ready(m_axis_tready),
    .res      (res)
  );

  assign m_axis_tdata = res;

endmodule

// ===== rtl/core/mav_checker.sv =====
`include "milenage_auth_vector_defines.svh"

module mav_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [175:0] s_axis_tdata,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [495:0] m_axis_tdata,
  input logic         cfg_we
);

  // a held result stays offered and keeps its value
  `MAV_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped or changed while stalled")
  // a waiting input stays offered and keeps its value
  `MAV_ASSERT_NEXT(a_in_hold, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata), "input dropped or changed while stalled")
  // nothing comes out right after reset
  `MAV_ASSERT_ALWAYS(a_rst_quiet, rst, !m_axis_tvalid, "result valid after reset")
  // a full queue drains as soon as the output side moves
  `MAV_ASSERT_NEXT(a_drain, !s_axis_tready && m_axis_tready, s_axis_tready, "queue stuck full")
  // the user is to let config writes land only while nothing is pending at the output; the block does not enforce it
  `MAV_ASSERT_NOW(a_cfg_idle, cfg_we, !m_axis_tvalid, "config write while a result is pending")

endmodule

bind milenage_auth_vector mav_checker u_mav_checker (.*);

// ===== dv/testbench.sv =====
module testbench import mav_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // DUT ports
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata  = '0;  // rand_high, rand_low, sequence_number
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [495:0] m_axis_tdata;        // expected_response, cipher_key_high,
                                     // cipher_key_low, integrity_key_high,
                                     // integrity_key_low, anonymity_key,
                                     // autn_high, autn_low
  logic         cfg_we    = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [63:0]  cfg_data  = '0;

  milenage_auth_vector dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Shadow copy of the register file
  blk_t        sub_key = '0;
  blk_t        op_const = '0;
  logic [15:0] amf = '0;

  logic [175:0] challenges [$];   // items waiting for the driver
  vec_t         vectors_due [$];  // predicted vectors, oldest first
  int           errors = 0;

  // GF(2^8) doubling
  function automatic logic [7:0] gf_double(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128 encryption; byte 0 sits in bits 127:120
  function automatic blk_t aes128_block(blk_t key, blk_t pt);
    blk_t        rk, st;
    logic [7:0]  t [16];
    logic [7:0]  rc, a0, a1, a2, a3, sum;
    logic [31:0] w0, w1, w2, w3, sub;
    rk = key;
    st = pt ^ rk;
    rc = 8'h01;
    for (int round = 1; round <= 10; round++) begin
      w0 = rk[127:96];
      w1 = rk[95:64];
      w2 = rk[63:32];
      w3 = rk[31:0];
      sub = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 ^= sub;
      w1 ^= w0;
      w2 ^= w1;
      w3 ^= w2;
      rk = {w0, w1, w2, w3};
      rc = gf_double(rc);
      // SubBytes with ShiftRows folded into the index
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          t[r + 4 * c] = SBOX[st[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]];
      if (round < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4 * c];
          a1 = t[4 * c + 1];
          a2 = t[4 * c + 2];
          a3 = t[4 * c + 3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          t[4 * c]     = a0 ^ sum ^ gf_double(a0 ^ a1);
          t[4 * c + 1] = a1 ^ sum ^ gf_double(a1 ^ a2);
          t[4 * c + 2] = a2 ^ sum ^ gf_double(a2 ^ a3);
          t[4 * c + 3] = a3 ^ sum ^ gf_double(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++)
        st[127 - 8 * i -: 8] = t[i] ^ rk[127 - 8 * i -: 8];
    end
    return st;
  endfunction

  // Full authentication vector for one challenge under the shadow registers
  function automatic vec_t milenage_vector(logic [175:0] item);
    blk_t        rnd, temp, a, in1, o1, o2, o3, o4;
    logic [47:0] sqn, ak;
    vec_t        v;
    rnd  = {item[63:0], item[127:64]};
    sqn  = item[175:128];
    temp = aes128_block(sub_key, rnd ^ op_const);
    a    = temp ^ op_const;
    o2 = aes128_block(sub_key, a ^ 128'h01) ^ op_const;
    o3 = aes128_block(sub_key, {a[95:0], a[127:96]} ^ 128'h02) ^ op_const;
    o4 = aes128_block(sub_key, {a[63:0], a[127:64]} ^ 128'h04) ^ op_const;
    in1 = {sqn, amf, sqn, amf} ^ op_const;
    o1 = aes128_block(sub_key, {in1[63:0], in1[127:64]} ^ temp) ^ op_const;
    ak = o2[127:80];
    v.expected_response  = o2[63:0];
    v.cipher_key_high    = o3[127:64];
    v.cipher_key_low     = o3[63:0];
    v.integrity_key_high = o4[127:64];
    v.integrity_key_low  = o4[63:0];
    v.anonymity_key      = ak;
    v.autn_high          = {sqn ^ ak, amf};
    v.autn_low           = o1[127:64];
    return v;
  endfunction

  // Driver: bursts of random length, random gaps between
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) vectors_due.push_back(milenage_vector(s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left      <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (challenges.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= challenges.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern, mode redrawn each time stall_ctr wraps
  logic [6:0] stall_ctr  = '0;
  int         stall_mode = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_ctr <= stall_ctr + 1'b1;
      if (stall_ctr == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (stall_ctr[3:0] < 4'd10);
      endcase
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Monitor: every output transfer against the oldest prediction
  always @(posedge clk) begin
    vec_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = vec_t'(m_axis_tdata);
      if (vectors_due.size() == 0) begin
        $display("%0t: unexpected vector, expected none actual %h", $realtime, got);
        errors++;
      end else begin
        want = vectors_due.pop_front();
        check_field("expected_response", want.expected_response, got.expected_response);
        check_field("cipher_key_high", want.cipher_key_high, got.cipher_key_high);
        check_field("cipher_key_low", want.cipher_key_low, got.cipher_key_low);
        check_field("integrity_key_high", want.integrity_key_high, got.integrity_key_high);
        check_field("integrity_key_low", want.integrity_key_low, got.integrity_key_low);
        check_field("anonymity_key", {16'd0, want.anonymity_key},
                    {16'd0, got.anonymity_key});
        check_field("autn_high", want.autn_high, got.autn_high);
        check_field("autn_low", want.autn_low, got.autn_low);
      end
    end
  end

  // Register write, mirrored into the shadow copy
  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_KEY_HIGH: sub_key[127:64]  = value;
      REG_KEY_LOW:  sub_key[63:0]    = value;
      REG_OPC_HIGH: op_const[127:64] = value;
      REG_OPC_LOW:  op_const[63:0]   = value;
      REG_AMF:      amf              = value[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(blk_t k, blk_t opc, logic [63:0] amf_word);
    write_reg(REG_KEY_HIGH, k[127:64]);
    write_reg(REG_KEY_LOW, k[63:0]);
    write_reg(REG_OPC_HIGH, opc[127:64]);
    write_reg(REG_OPC_LOW, opc[63:0]);
    write_reg(REG_AMF, amf_word);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_item(logic [63:0] rh, logic [63:0] rl, logic [47:0] sqn);
    challenges.push_back({sqn, rl, rh});
  endtask

  // Block until every queued item is sent and every vector has come back,
  // then give the pipeline its latency before touching registers.
  task automatic drain();
    while (challenges.size() > 0 || s_axis_tvalid || vectors_due.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Registers at their reset value: field extremes
    queue_item('0, '0, '0);
    queue_item('1, '1, '1);
    queue_item(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 48'haaaaaaaaaaaa);
    queue_item(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 48'h555555555555);
    drain();

    // Published conformance set 1
    write_all(128'h465b5ce8b199b49faa5f0a2ee238a6bc,
              128'hcd63cb71954a9f4e48a5994e37a02baf, 64'hb9b9);
    queue_item(64'h23553cbe9637a89d, 64'h218ae64dae47bf35, 48'hff9bb4d0b607);
    queue_item('0, '1, 48'h000000000001);
    queue_item('1, '0, 48'h800000000000);
    drain();

    // All-ones registers, upper AMF write bits set too
    write_all('1, '1, '1);
    queue_item('0, '0, '1);
    queue_item('1, '1, '0);
    queue_item(64'h0123456789abcdef, 64'hfedcba9876543210, 48'h0123456789ab);
    drain();

    // All-zero registers written explicitly
    write_all('0, '0, '0);
    queue_item('1, '1, '1);
    queue_item(64'h8000000000000001, 64'h0000000000000001, 48'h800000000001);
    drain();

    // Random settings, random challenges
    for (int phase = 0; phase < 7; phase++) begin
      write_all({rand64(), rand64()}, {rand64(), rand64()}, rand64());
      for (int n = 0; n < 200; n++) begin
        case ($urandom_range(0, 15))
          0: queue_item('0, rand64(), 48'(rand64()));
          1: queue_item('1, rand64(), '1);
          2: queue_item(rand64(), '0, '0);
          default: queue_item(rand64(), rand64(), 48'(rand64()));
        endcase
      end
      drain();
    end

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
